// ===== design/resonant_two_pole_lowpass_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the resonant two-pole lowpass
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RESONANT_TWO_POLE_LOWPASS_DEFINES_SVH
`define RESONANT_TWO_POLE_LOWPASS_DEFINES_SVH

// ante implies cons in the same cycle
`define RTPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define RTPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rtpl_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpl_pkg
// Types, constants, microcode table and saturation helpers of the lowpass.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpl_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CUTOFF_W = 16;
  localparam int RES_W    = 16;
  localparam int STAGE_W  = 32;
  localparam int PC_W     = 4;

  localparam logic [CUTOFF_W-1:0] CUTOFF_MAX = 16'd65529;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_WAIT     = 4'd0;
  localparam pc_t STEP_DIV_INIT = 4'd1;
  localparam pc_t STEP_DIV      = 4'd2;
  localparam pc_t STEP_FB       = 4'd3;
  localparam pc_t STEP_MUL_LO   = 4'd4;
  localparam pc_t STEP_MUL_HI   = 4'd5;
  localparam pc_t STEP_ACC      = 4'd6;
  localparam pc_t STEP_TERM     = 4'd7;
  localparam pc_t STEP_MUL_T    = 4'd8;
  localparam pc_t STEP_NS0      = 4'd9;
  localparam pc_t STEP_DIFF     = 4'd10;
  localparam pc_t STEP_MUL_D    = 4'd11;
  localparam pc_t STEP_NS1      = 4'd12;
  localparam pc_t STEP_EMIT     = 4'd13;
  localparam pc_t STEP_RET      = 4'd14;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FB,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ACC,
    OP_TERM,
    OP_MUL_T,
    OP_NS0,
    OP_DIFF,
    OP_MUL_D,
    OP_NS1,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_CNT_NZ,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      STEP_WAIT:     w = '{OP_LOAD,     COND_NO_INPUT, STEP_WAIT};
      STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEVER,    STEP_WAIT};
      STEP_DIV:      w = '{OP_DIV_STEP, COND_CNT_NZ,   STEP_DIV};
      STEP_FB:       w = '{OP_FB,       COND_NEVER,    STEP_WAIT};
      STEP_MUL_LO:   w = '{OP_MUL_LO,   COND_NEVER,    STEP_WAIT};
      STEP_MUL_HI:   w = '{OP_MUL_HI,   COND_NEVER,    STEP_WAIT};
      STEP_ACC:      w = '{OP_ACC,      COND_NEVER,    STEP_WAIT};
      STEP_TERM:     w = '{OP_TERM,     COND_NEVER,    STEP_WAIT};
      STEP_MUL_T:    w = '{OP_MUL_T,    COND_NEVER,    STEP_WAIT};
      STEP_NS0:      w = '{OP_NS0,      COND_NEVER,    STEP_WAIT};
      STEP_DIFF:     w = '{OP_DIFF,     COND_NEVER,    STEP_WAIT};
      STEP_MUL_D:    w = '{OP_MUL_D,    COND_NEVER,    STEP_WAIT};
      STEP_NS1:      w = '{OP_NS1,      COND_NEVER,    STEP_WAIT};
      STEP_EMIT:     w = '{OP_EMIT,     COND_OUT_BUSY, STEP_EMIT};
      default:       w = '{OP_NOP,      COND_ALWAYS,   STEP_WAIT};
    endcase
    return w;
  endfunction

  // clamp a 54-bit signed value to the signed 32-bit range
  function automatic logic signed [STAGE_W-1:0] sat32(input logic signed [53:0] v);
    logic signed [STAGE_W-1:0] r;
    if (!v[53] && (|v[52:31])) begin
      r = 32'sh7FFF_FFFF;
    end else if (v[53] && !(&v[52:31])) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q8.24 stage to Q1.15: floor shift by 9, clamp to 16 bits
  function automatic logic [SAMPLE_W-1:0] to_q15(input logic signed [STAGE_W-1:0] s);
    logic [SAMPLE_W-1:0] r;
    if (!s[31] && (|s[30:24])) begin
      r = 16'h7FFF;
    end else if (s[31] && !(&s[30:24])) begin
      r = 16'h8000;
    end else begin
      r = s[24:9];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/resonant_two_pole_lowpass.sv =====
// ----------------------------------------------------------------------------
// resonant_two_pole_lowpass
// Two-pole resonant lowpass run by a microcoded sequencer over one shared
// divider step and one shared 34x18 multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)          | tuser/tlast
//  in_     | slave     | sample_in[15:0] cutoff[15:0] | tlast = block_end
//  out_    | master    | sample_out[15:0]            | tlast = block_end_out
//  cfg_    | write     | resonance[15:0]             | -
//
//  An item runs from acceptance to the next ready through the one-bit-per-cycle
//  restoring divide for q/(1-f), then the multiply and update steps through the
//  single multiplier, then accept and return; no new item enters meanwhile.
//  Reset clears both stages, resonance and the sequencer; no clearing pass.
//  A stalled output holds the sequencer at its emit step; the output
//  register lets the next transaction enter while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "resonant_two_pole_lowpass_defines.svh"

module resonant_two_pole_lowpass (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rtpl_pkg::RES_W-1:0]   cfg_wr_data,  // resonance
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [31:0]                  in_tdata,     // sample_in, cutoff
  input  wire logic                         in_tlast,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [rtpl_pkg::SAMPLE_W-1:0]     out_tdata,    // sample_out
  output logic                              out_tlast
);
  import rtpl_pkg::*;

  // sequencer
  pc_t    pc_r, pc_nxt;
  ucode_t uword;
  logic   take_jump;
  logic   out_free;
  logic   emit_fire;

  // datapath
  logic [RES_W-1:0]          resonance_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [CUTOFF_W-1:0]       f_r;
  logic                      last_r;
  logic signed [STAGE_W-1:0] s0_r, s1_r;
  logic signed [STAGE_W:0]   diff_r;
  logic [16:0]               rem_r;
  logic [31:0]               dvd_r;
  logic [4:0]                cnt_r;
  logic [30:0]               fb_r;
  logic signed [51:0]        prod_r;
  logic signed [63:0]        acc_r;
  logic signed [STAGE_W-1:0] t_r;
  logic [SAMPLE_W-1:0]       out_data_r;
  logic                      out_last_r;
  logic                      out_valid_r;

  logic [CUTOFF_W-1:0]       cutoff_in;
  logic [16:0]               divisor;
  logic [18:0]               trial;
  logic [32:0]               fb_sum;
  logic signed [33:0]        mul_a;
  logic signed [17:0]        mul_b;
  logic signed [51:0]        mul_p;
  logic signed [53:0]        term_sum;
  logic signed [53:0]        ns0_sum;
  logic signed [53:0]        ns1_sum;
  logic signed [STAGE_W:0]   stage_diff;

  assign uword = ucode_rom(pc_r);

  // next step
  always_comb begin
    unique case (uword.cond)
      COND_NEVER:    take_jump = 1'b0;
      COND_ALWAYS:   take_jump = 1'b1;
      COND_NO_INPUT: take_jump = !in_tvalid;
      COND_CNT_NZ:   take_jump = (cnt_r != '0);
      COND_OUT_BUSY: take_jump = out_valid_r && !out_tready;
      default:       take_jump = 1'b0;
    endcase
    pc_nxt = take_jump ? uword.target : pc_t'(pc_r + 1'b1);
  end

  // step outputs
  always_comb begin
    in_tready = (uword.op == OP_LOAD);
    out_free  = !out_valid_r || out_tready;
    emit_fire = (uword.op == OP_EMIT) && out_free;
  end

  assign cutoff_in = in_tdata[31:16];
  assign divisor   = 17'h1_0000 - {1'b0, f_r};
  assign trial     = {1'b0, rem_r, dvd_r[31]} - {2'b00, divisor};
  assign fb_sum    = {17'h0, resonance_r} + {1'b0, dvd_r};

  always_comb begin
    unique case (uword.op)
      OP_MUL_LO: begin
        mul_a = {3'b000, fb_r};
        mul_b = {2'b00, diff_r[15:0]};
      end
      OP_MUL_HI: begin
        mul_a = {3'b000, fb_r};
        mul_b = {diff_r[32], diff_r[32:16]};
      end
      OP_MUL_T: begin
        mul_a = {{2{t_r[31]}}, t_r};
        mul_b = {2'b00, f_r};
      end
      OP_MUL_D: begin
        mul_a = {diff_r[32], diff_r};
        mul_b = {2'b00, f_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // acc >>> 12, plus x in Q8.24, minus stage one
  assign term_sum = {{2{acc_r[63]}}, acc_r[63:12]}
                  + {{29{x_r[15]}}, x_r, 9'h000}
                  - {{22{s0_r[31]}}, s0_r};
  assign ns0_sum  = {{22{s0_r[31]}}, s0_r} + {{18{prod_r[51]}}, prod_r[51:16]};
  assign ns1_sum  = {{22{s1_r[31]}}, s1_r} + {{18{prod_r[51]}}, prod_r[51:16]};
  assign stage_diff = {s0_r[31], s0_r} - {s1_r[31], s1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_WAIT;
      out_valid_r <= 1'b0;
      resonance_r <= '0;
      s0_r        <= '0;
      s1_r        <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr_en) begin
        resonance_r <= cfg_wr_data;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (uword.op == OP_NS0) begin
        s0_r <= sat32(ns0_sum);
      end
      if (uword.op == OP_NS1) begin
        s1_r <= sat32(ns1_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (uword.op)
      OP_LOAD: begin
        if (in_tvalid) begin
          x_r    <= in_tdata[15:0];
          f_r    <= (cutoff_in > CUTOFF_MAX) ? CUTOFF_MAX : cutoff_in;
          last_r <= in_tlast;
        end
      end
      OP_DIV_INIT: begin
        rem_r  <= '0;
        dvd_r  <= {resonance_r, 16'h0000};
        cnt_r  <= 5'd31;
        diff_r <= stage_diff;
      end
      OP_DIV_STEP: begin
        // restoring step, quotient bits shift in behind the dividend
        if (!trial[18]) begin
          rem_r <= trial[16:0];
        end else begin
          rem_r <= {rem_r[15:0], dvd_r[31]};
        end
        dvd_r <= {dvd_r[30:0], !trial[18]};
        cnt_r <= cnt_r - 1'b1;
      end
      OP_FB: begin
        fb_r <= (|fb_sum[32:31]) ? 31'h7FFF_FFFF : fb_sum[30:0];
      end
      OP_MUL_LO: begin
        prod_r <= mul_p;
      end
      OP_MUL_HI: begin
        prod_r <= mul_p;
        acc_r  <= {{12{prod_r[51]}}, prod_r};
      end
      OP_ACC: begin
        // high partial product fits 48 signed bits
        acc_r <= acc_r + {prod_r[47:0], 16'h0000};
      end
      OP_TERM: begin
        t_r <= sat32(term_sum);
      end
      OP_MUL_T: begin
        prod_r <= mul_p;
      end
      OP_DIFF: begin
        diff_r <= stage_diff;
      end
      OP_MUL_D: begin
        prod_r <= mul_p;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_data_r <= to_q15(s1_r);
          out_last_r <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `RTPL_ASSERT_NEXT(a_accept_starts_div, in_tvalid && in_tready, pc_r == STEP_DIV_INIT, "accepted transaction did not start the divide")
  `RTPL_ASSERT_NEXT(a_div_exit, (pc_r == STEP_DIV) && (cnt_r == '0), pc_r == STEP_FB, "divide loop did not exit after last step")
  `RTPL_ASSERT_NOW(a_valid_from_emit, $rose(out_valid_r), $past(pc_r) == STEP_EMIT, "result raised outside the emit step")
  `RTPL_ASSERT_NEXT(a_emit_holds, (pc_r == STEP_EMIT) && out_valid_r && !out_tready, (pc_r == STEP_EMIT) && out_valid_r, "sequencer left emit while output was stalled")
  `RTPL_ASSERT_NEXT(a_emit_loads, (pc_r == STEP_EMIT) && !(out_valid_r && !out_tready), out_valid_r && (pc_r == STEP_RET), "free output not loaded at emit")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: resonant two-pole lowpass testbench
// Streams audio samples with per-sample cutoff through the filter under
// several resonance settings. A behavioral model of both filter stages
// predicts every output sample that has no hand-worked value. Both stream sides idle at random, and the
// receiver stalls once for long enough to back the filter up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpl_pkg::*;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 190;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 60;   // a margin over the time one item takes
  localparam int WATCHDOG_MAX  = 4000;

  typedef enum logic {ROW_ITEM, ROW_RES} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;   // sample_in, or resonance for ROW_RES
    logic [15:0] cutoff;
    logic        last;
    logic        typed;   // want holds a hand-worked output
    logic [15:0] want;
  } stim_row_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } filt_out_t;

  localparam int DIR_ROWS = 21;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // zero state, zero resonance: output stays zero
    '{ROW_ITEM, 16'h0000, 16'd0,     1'b0, 1'b1, 16'h0000},
    // cutoff zero freezes the stages whatever the input
    '{ROW_ITEM, 16'h7FFF, 16'd0,     1'b0, 1'b1, 16'h0000},
    '{ROW_ITEM, 16'h8000, 16'd0,     1'b1, 1'b1, 16'h0000},
    // cutoff above, at and below the clamp
    '{ROW_ITEM, 16'h7FFF, 16'd65535, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h8000, 16'd65530, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h0000, 16'd65529, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h4000, 16'd32768, 1'b1, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'hFFFF, 16'd1,     1'b0, 1'b0, 16'h0000},
    // full resonance, full-scale square wave: drives the inner term,
    // the stages and the output into saturation
    '{ROW_RES,  16'hFFFF, 16'd0,     1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h7FFF, 16'd65535, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h8000, 16'd65535, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h7FFF, 16'd65535, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h8000, 16'd65535, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h7FFF, 16'd65535, 1'b1, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h8000, 16'd65535, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h0000, 16'd65535, 1'b0, 1'b0, 16'h0000},
    '{ROW_RES,  16'd4096, 16'd0,     1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h7FFF, 16'd40000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd12345, 16'd1000, 1'b1, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h8000, 16'd65535, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'hB1E0, 16'd20000, 1'b1, 1'b0, 16'h0000}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // sample_in[15:0], cutoff[31:16]
  logic        in_tlast;   // block_end
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // sample_out[15:0]
  logic        out_tlast;  // block_end_out

  // filter model state
  logic [15:0]       resonance_m;
  longint            stage_one_m;
  longint            stage_two_m;
  filt_out_t         pending_out[$];

  int  errors;
  int  samples_sent;
  int  samples_seen;
  int  block_ends;
  int  settings_used;
  bit  calm;          // no idling on either side

  resonant_two_pole_lowpass dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one filter update; shifts of signed longints floor toward minus infinity
  function automatic filt_out_t lowpass_predict(input logic [15:0] smp,
                                                input logic [15:0] cut,
                                                input logic last);
    longint    x, f, fb, s0, s1, t, ns0, ns1, y;
    filt_out_t r;
    x  = longint'($signed(smp));
    f  = (cut > CUTOFF_MAX) ? longint'(CUTOFF_MAX) : longint'(cut);
    fb = longint'(resonance_m) + (longint'(resonance_m) <<< 16) / (64'sd65536 - f);
    if (fb > 64'sd2147483647) fb = 64'sd2147483647;
    s0 = stage_one_m;
    s1 = stage_two_m;
    t   = (fb * (s0 - s1)) >>> 12;
    t   = clamp32(t + x * 512 - s0);
    ns0 = clamp32(s0 + ((f * t) >>> 16));
    ns1 = clamp32(s1 + ((f * (ns0 - s1)) >>> 16));
    stage_one_m = ns0;
    stage_two_m = ns1;
    y = ns1 >>> 9;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    r.sample = y[15:0];
    r.last   = last;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom % 16;
    if (r < 9) return 0;
    if (r < 15) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_sample(input logic [15:0] smp, input logic [15:0] cut,
                             input logic last, input logic typed,
                             input logic [15:0] want);
    filt_out_t e;
    int        gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {cut, smp};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    e = lowpass_predict(smp, cut, last);
    if (typed) e.sample = want;
    pending_out.push_back(e);
    samples_sent++;
    if (last) block_ends++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register writes only with the filter empty
  task automatic write_resonance(input logic [15:0] v);
    in_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    resonance_m = v;
    settings_used++;
  endtask

  function automatic logic [15:0] rand_sample();
    unique case ($urandom % 8)
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return ($urandom % 2) ? 16'($urandom_range(0, 63))
                                     : 16'(-$urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_cutoff();
    unique case ($urandom % 8)
      0:       return 16'($urandom_range(65520, 65535));
      1:       return 16'($urandom_range(0, 16));
      2:       return 16'($urandom_range(60000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [15:0] res_plan [RANDOM_PHASES];
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    errors        = 0;
    samples_sent  = 0;
    samples_seen  = 0;
    block_ends    = 0;
    settings_used = 1;
    calm          = 1'b0;
    resonance_m   = '0;
    stage_one_m   = 0;
    stage_two_m   = 0;
    res_plan = '{16'd0, 16'hFFFF, 16'd4096, 16'd1, 16'($urandom),
                 16'($urandom), 16'd14000, 16'($urandom_range(0, 8192))};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_RES) begin
        write_resonance(DIRECTED[i].value);
      end else begin
        send_sample(DIRECTED[i].value, DIRECTED[i].cutoff, DIRECTED[i].last,
                    DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_resonance(res_plan[p]);
      calm = (p == 2);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        send_sample(rand_sample(), rand_cutoff(), ($urandom % 8) == 0, 1'b0, 16'h0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d samples (%0d block ends) under %0d resonance settings",
             samples_seen, block_ends, settings_used);
    if (errors == 0) begin
      $display("[resonant_two_pole_lowpass] OK");
    end else begin
      $display("[resonant_two_pole_lowpass] ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    filt_out_t want;
    int        hold_cnt;
    bit        long_done;
    hold_cnt   = 0;
    long_done  = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_out.size() == 0) begin
          $error("sample_out %h arrived with no sample pending", out_tdata);
          errors++;
        end else begin
          want = pending_out.pop_front();
          if (out_tdata !== want.sample) begin
            $error("sample_out: expected %0d, got %0d", $signed(want.sample),
                   $signed(out_tdata));
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("block_end_out: expected %0b, got %0b", want.last, out_tlast);
            errors++;
          end
          samples_seen++;
        end
      end
      // one long hold-off lets the filter fill and stall its input
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (!long_done && samples_seen >= 150) begin
        long_done = 1'b1;
        hold_cnt  = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (!calm && ($urandom % 5) == 0) begin
        hold_cnt = pick_gap();
        out_tready <= (hold_cnt == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= WATCHDOG_MAX) begin
        $display("[resonant_two_pole_lowpass] ERROR");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/rtpl_pkg.sv
design/resonant_two_pole_lowpass.sv
verif/tb.sv
